>>> rtl/awtm_pkg.sv
// Package of the averaged weight additive tone mixer: types, constants and the cosine generator.
`default_nettype none
package awtm_pkg;

  // Microseconds per second; the phase of every note is reduced modulo this.
  localparam int unsigned US_PER_S = 1000000;
  // Modulo unit: the dividend loses its six low bits (one million is 64 * 15625), and the
  // quotient is estimated by a reciprocal of 15625, then corrected by one compare.
  localparam int unsigned DIV_X_W = 33;
  localparam int unsigned DIV_Q_W = 13;
  localparam int unsigned DIV_R_W = 20;
  localparam int unsigned DIV_PRE_SHIFT = 6;
  localparam int unsigned DIV_Y_W = DIV_X_W - DIV_PRE_SHIFT;
  localparam int unsigned DIV_M_W = 27;
  localparam int unsigned DIV_RECIP_SHIFT = 40;
  localparam int unsigned DIV_E_W = DIV_Y_W + DIV_M_W - DIV_RECIP_SHIFT;
  localparam logic [DIV_M_W-1:0] DIV_RECIP =
      DIV_M_W'((64'd1 << DIV_RECIP_SHIFT) / 64'(US_PER_S >> DIV_PRE_SHIFT));

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COS_W = 16;
  localparam int unsigned DUTY_W = 16;
  localparam int unsigned MAX_NOTES = 8;
  localparam int unsigned FREQ_W = 10;

  localparam int unsigned DEF_HISTORY_DEPTH = 4;
  localparam int unsigned DEF_NOTE_COUNT = 8;
  localparam int unsigned DEF_COS_TABLE_ENTRIES = 1024;
  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 8'd120;

  localparam int unsigned NOTE_FREQ [MAX_NOTES] = '{200, 300, 350, 450, 550, 650, 700, 800};

  localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_DIV,
    ST_F_RING,
    ST_F_AVG,
    ST_F_WRITE,
    ST_S_TSTART,
    ST_S_TWAIT,
    ST_S_PSTART,
    ST_S_PWAIT,
    ST_S_ISTART,
    ST_S_IWAIT,
    ST_S_COS,
    ST_S_MUL,
    ST_S_ACC,
    ST_S_DONE
  } awtm_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Cosine of 2*pi*k/n in Q1.15, from a Taylor series in Q28; evaluated at elaboration only.
  function automatic logic signed [COS_W-1:0] cos_entry(input int unsigned k,
                                                        input int unsigned n);
    logic [63:0] kf;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] v;
    logic signed [63:0] q;
    kf = (k <= n - k) ? 64'(k) : 64'(n - k);
    th = (kf * TWO_PI_Q28 + 64'(n / 2)) / 64'(n);
    th2 = (th * th) >> 28;
    term = 64'd1 << 28;
    sum = signed'(term);
    for (int i = 1; i <= 12; i++) begin
      term = ((term * th2) >> 28) / 64'((2 * i - 1) * (2 * i));
      if ((i % 2) == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    v = unsigned'(sum + 64'sd4096 + (64'sd1 <<< 30)) >> 13;
    q = signed'(v) - (64'sd1 <<< 17);
    if (q > 64'sd32767) q = 64'sd32767;
    if (q < -64'sd32768) q = -64'sd32768;
    return q[COS_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/awtm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module awtm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/awtm_div.sv
// Modulo-one-million unit: quotient and remainder by a reciprocal multiplication.
`default_nettype none
module awtm_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [awtm_pkg::DIV_X_W-1:0]  x_i,
  output awtm_pkg::div_stat_t                stat_o,
  output logic      [awtm_pkg::DIV_Q_W-1:0]  q_o,
  output logic      [awtm_pkg::DIV_R_W-1:0]  r_o
);
  import awtm_pkg::*;

  localparam int unsigned PROD_W = DIV_Y_W + DIV_M_W;

  logic               s1_q, s2_q, done_q;
  logic [DIV_X_W-1:0] x_q;
  logic [DIV_Y_W-1:0] y;
  logic [PROD_W-1:0]  prod_q;
  logic [DIV_E_W-1:0] qe, qe_q;
  logic [DIV_X_W-1:0] back;
  logic [DIV_R_W:0]   re_q;
  logic               ge;

  // The estimate is the true quotient or one below it, so the remainder is under two million.
  assign y    = x_q[DIV_X_W-1:DIV_PRE_SHIFT];
  assign qe   = prod_q[DIV_RECIP_SHIFT +: DIV_E_W];
  assign back = DIV_X_W'(qe) * DIV_X_W'(US_PER_S);
  assign ge   = (re_q >= (DIV_R_W+1)'(US_PER_S));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) x_q <= x_i;
    if (s1_q) prod_q <= PROD_W'(y) * PROD_W'(DIV_RECIP);
    if (s2_q) begin
      qe_q <= qe;
      re_q <= (DIV_R_W+1)'(x_q - back);
    end
  end

  assign stat_o.busy = s1_q | s2_q;
  assign stat_o.done = done_q;
  assign q_o = DIV_Q_W'(qe_q + DIV_E_W'(ge));
  assign r_o = ge ? DIV_R_W'(re_q - (DIV_R_W+1)'(US_PER_S)) : re_q[DIV_R_W-1:0];

endmodule
`default_nettype wire

>>> rtl/averaged_weight_additive_tone_mixer_unit.sv
// Top level of the averaged weight additive tone mixer.
// Usage: one input channel (in_valid_i/in_ready_o) carries either a frame
// transaction (operation_i = 0, eight string levels) or a sample transaction
// (operation_i = 1, a time in microseconds). A frame yields no result; it turns
// the levels into weights, stores them in a ring of HISTORY_DEPTH frames held in
// RAM and rewrites the per-note averages in a second RAM. A sample yields one
// duty value on the output channel (out_valid_o/out_ready_i).
// The block works on one transaction at a time; in_ready_o is high only when
// idle. A frame's time is set by the sixteen-step divider per note and the
// one-read-per-cycle history RAM port. A sample's time is set by the shared
// modulo-one-million unit, used twice per note for phase and table index.
// The result sits in an output register; a new transaction is accepted while it
// waits, and a later sample stalls in its last step until the register is free.
// Reset clears the history ring (by per-frame valid bits, no clearing pass), the
// averages, the ring slot and sets the threshold to 120. The threshold port
// (cfg_valid_i/cfg_data_i) is always ready and is meant to be written only while idle.
`default_nettype none
module averaged_weight_additive_tone_mixer_unit #(
  parameter int unsigned HISTORY_DEPTH = awtm_pkg::DEF_HISTORY_DEPTH,
  parameter int unsigned NOTE_COUNT = awtm_pkg::DEF_NOTE_COUNT,
  parameter int unsigned COS_TABLE_ENTRIES = awtm_pkg::DEF_COS_TABLE_ENTRIES
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [awtm_pkg::LEVEL_W-1:0]   cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           operation_i,
  input  wire logic [awtm_pkg::LEVEL_W-1:0]   level_0_i,
  input  wire logic [awtm_pkg::LEVEL_W-1:0]   level_1_i,
  input  wire logic [awtm_pkg::LEVEL_W-1:0]   level_2_i,
  input  wire logic [awtm_pkg::LEVEL_W-1:0]   level_3_i,
  input  wire logic [awtm_pkg::LEVEL_W-1:0]   level_4_i,
  input  wire logic [awtm_pkg::LEVEL_W-1:0]   level_5_i,
  input  wire logic [awtm_pkg::LEVEL_W-1:0]   level_6_i,
  input  wire logic [awtm_pkg::LEVEL_W-1:0]   level_7_i,
  input  wire logic [31:0]                    time_us_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [awtm_pkg::DUTY_W-1:0]    duty_o
);
  import awtm_pkg::*;

  localparam int unsigned NOTE_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int unsigned ROW_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned HIST_DEPTH = HISTORY_DEPTH * NOTE_COUNT;
  localparam int unsigned HA_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned CIDX_W = $clog2(COS_TABLE_ENTRIES);
  localparam int unsigned SUM_W = 11;
  // Ring average: exact floor division by HISTORY_DEPTH through a reciprocal.
  localparam int unsigned AVG_SUM_W = $clog2(HISTORY_DEPTH * 32768 + 1);
  localparam int unsigned AVG_L = $clog2(HISTORY_DEPTH);
  localparam int unsigned AVG_SHIFT = AVG_SUM_W + AVG_L;
  localparam int unsigned MULT_W = AVG_SUM_W + 2;
  localparam logic [MULT_W-1:0] AVG_MULT =
      MULT_W'(((64'd1 << AVG_SHIFT) / 64'(HISTORY_DEPTH)) + 64'd1);
  localparam int unsigned AVG_PROD_W = AVG_SUM_W + MULT_W;
  localparam int unsigned ACC_W = 40;

  awtm_state_e state_q, state_d;

  // Configuration and input capture.
  logic [LEVEL_W-1:0] thr_q;
  logic [LEVEL_W-1:0] lvl_in [MAX_NOTES];
  logic [LEVEL_W-1:0] lvl_q  [NOTE_COUNT];
  logic [SUM_W-1:0]   sum_in, sum_q;
  logic [31:0]        t_q;
  logic               in_fire;

  // Frame path.
  logic [NOTE_W-1:0]    note_q;
  logic [3:0]           dstep_q;
  logic [SUM_W-1:0]     r_q;
  logic [WEIGHT_W-1:0]  quo_q, w_q;
  logic [SUM_W:0]       cand;
  logic                 qbit;
  logic [ROW_W-1:0]     slot_q, rrow_q, rd_row_q;
  logic                 rissue_q, rd_vld_q;
  logic [HISTORY_DEPTH-1:0] row_valid_q;
  logic                 act_valid_q;
  logic [AVG_SUM_W-1:0] avg_acc_q;
  logic [WEIGHT_W-1:0]  ring_val;
  logic [AVG_PROD_W-1:0] avg_prod_q;

  // Sample path.
  logic [DIV_R_W-1:0]   tm_q, p_q;
  logic [CIDX_W-1:0]    idx_q;
  logic signed [COS_W-1:0] cos_q;
  logic signed [COS_W-1:0] cos_rom [COS_TABLE_ENTRIES];
  logic signed [WEIGHT_W+COS_W:0] mprod_q;
  logic signed [ACC_W-1:0] sacc_q;
  logic signed [ACC_W-1:0] duty_full;
  logic [DUTY_W-1:0]    duty_sat;
  logic                 out_valid_q;
  logic [DUTY_W-1:0]    duty_q;

  // Memory and divider control.
  logic                 hist_we, hist_re, act_we, act_re;
  logic [HA_W-1:0]      hist_waddr, hist_raddr;
  logic [WEIGHT_W-1:0]  hist_rdata, act_rdata, act_w;
  logic                 div_start;
  logic [DIV_X_W-1:0]   div_x;
  div_stat_t            div_stat;
  logic [DIV_Q_W-1:0]   div_q;
  logic [DIV_R_W-1:0]   div_r;
  logic                 last_note;

  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign last_note   = (note_q == NOTE_W'(NOTE_COUNT - 1));

  assign lvl_in = '{level_0_i, level_1_i, level_2_i, level_3_i,
                    level_4_i, level_5_i, level_6_i, level_7_i};

  // Levels under the threshold count as silent.
  always_comb begin
    sum_in = '0;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      if (lvl_in[i] >= thr_q) sum_in = sum_in + SUM_W'(lvl_in[i]);
    end
  end

  // The cosine table is a constant ROM, filled at elaboration.
  for (genvar k = 0; k < COS_TABLE_ENTRIES; k++) begin : g_cos
    localparam logic signed [COS_W-1:0] COS_K = cos_entry(k, COS_TABLE_ENTRIES);
    assign cos_rom[k] = COS_K;
  end

  // Restoring division level * 2^15 / sum, one quotient bit a cycle. The first
  // step uses the level itself, since the level never exceeds the sum.
  assign cand = (dstep_q == 4'd0) ? (SUM_W+1)'(lvl_q[note_q]) : {r_q, 1'b0};
  assign qbit = (sum_q != '0) && (cand >= {1'b0, sum_q});

  // The slot being written reads as the new weight; rows never written read as zero.
  always_comb begin
    if (rd_row_q == slot_q) ring_val = w_q;
    else if (row_valid_q[rd_row_q]) ring_val = hist_rdata;
    else ring_val = '0;
  end

  assign act_w = act_valid_q ? act_rdata : '0;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_fire) state_d = operation_i ? ST_S_TSTART : ST_F_DIV;
      ST_F_DIV:    if (dstep_q == 4'd15) state_d = ST_F_RING;
      ST_F_RING:   if (rd_vld_q && rd_row_q == ROW_W'(HISTORY_DEPTH - 1)) state_d = ST_F_AVG;
      ST_F_AVG:    state_d = ST_F_WRITE;
      ST_F_WRITE:  state_d = last_note ? ST_IDLE : ST_F_DIV;
      ST_S_TSTART: state_d = ST_S_TWAIT;
      ST_S_TWAIT:  if (div_stat.done) state_d = ST_S_PSTART;
      ST_S_PSTART: state_d = ST_S_PWAIT;
      ST_S_PWAIT:  if (div_stat.done) state_d = ST_S_ISTART;
      ST_S_ISTART: state_d = ST_S_IWAIT;
      ST_S_IWAIT:  if (div_stat.done) state_d = ST_S_COS;
      ST_S_COS:    state_d = ST_S_MUL;
      ST_S_MUL:    state_d = ST_S_ACC;
      ST_S_ACC:    state_d = last_note ? ST_S_DONE : ST_S_PSTART;
      ST_S_DONE:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Memory and divider controls.
  always_comb begin
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    act_we     = 1'b0;
    act_re     = 1'b0;
    div_start  = 1'b0;
    div_x      = '0;
    hist_waddr = HA_W'(int'(slot_q) * NOTE_COUNT + int'(note_q));
    hist_raddr = HA_W'(int'(rrow_q) * NOTE_COUNT + int'(note_q));
    case (state_q)
      ST_F_DIV:    hist_we = (dstep_q == 4'd15);
      ST_F_RING:   hist_re = rissue_q;
      ST_F_WRITE:  act_we = 1'b1;
      ST_S_TSTART: begin
        div_start = 1'b1;
        div_x     = DIV_X_W'(t_q);
      end
      ST_S_PSTART: begin
        div_start = 1'b1;
        div_x     = DIV_X_W'(FREQ_W'(NOTE_FREQ[note_q])) * DIV_X_W'(tm_q);
      end
      ST_S_ISTART: begin
        div_start = 1'b1;
        div_x     = DIV_X_W'(p_q) * DIV_X_W'(COS_TABLE_ENTRIES) + DIV_X_W'(US_PER_S / 2);
      end
      ST_S_COS:    act_re = 1'b1;
      default:     ;
    endcase
  end

  // Duty: 0.5 plus the weighted cosines, rounded and saturated.
  always_comb begin
    duty_full = (sacc_q + ACC_W'(16384)) >>> 15;
    if (duty_full < 0) duty_sat = '0;
    else if (duty_full > ACC_W'(65535)) duty_sat = '1;
    else duty_sat = duty_full[DUTY_W-1:0];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THRESHOLD_RESET;
      note_q      <= '0;
      dstep_q     <= '0;
      slot_q      <= '0;
      rrow_q      <= '0;
      rissue_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_row_q    <= '0;
      row_valid_q <= '0;
      act_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) thr_q <= cfg_data_i;
      // The output register fills at the end of a sample and empties when taken.
      if (state_q == ST_S_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      rd_vld_q <= (state_q == ST_F_RING) && rissue_q;
      case (state_q)
        ST_IDLE: begin
          note_q  <= '0;
          dstep_q <= '0;
        end
        ST_F_DIV: begin
          dstep_q <= dstep_q + 4'd1;
          if (dstep_q == 4'd15) begin
            rrow_q   <= '0;
            rissue_q <= 1'b1;
          end
        end
        ST_F_RING: begin
          if (rissue_q) begin
            rd_row_q <= rrow_q;
            if (rrow_q == ROW_W'(HISTORY_DEPTH - 1)) rissue_q <= 1'b0;
            else rrow_q <= rrow_q + ROW_W'(1);
          end
        end
        ST_F_WRITE: begin
          dstep_q <= '0;
          if (last_note) begin
            row_valid_q[slot_q] <= 1'b1;
            act_valid_q <= 1'b1;
            slot_q <= (slot_q == ROW_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + ROW_W'(1);
          end else begin
            note_q <= note_q + NOTE_W'(1);
          end
        end
        ST_S_ACC: if (!last_note) note_q <= note_q + NOTE_W'(1);
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < NOTE_COUNT; i++) begin
        lvl_q[i] <= (lvl_in[i] < thr_q) ? '0 : lvl_in[i];
      end
      sum_q <= sum_in;
      t_q   <= time_us_i;
      sacc_q <= ACC_W'(32768) <<< 15;
    end
    case (state_q)
      ST_F_DIV: begin
        r_q   <= qbit ? SUM_W'(cand - (SUM_W+1)'(sum_q)) : SUM_W'(cand);
        quo_q <= (dstep_q == 4'd0) ? WEIGHT_W'(qbit) : {quo_q[WEIGHT_W-2:0], qbit};
        if (dstep_q == 4'd15) begin
          w_q       <= {quo_q[WEIGHT_W-2:0], qbit};
          avg_acc_q <= '0;
        end
      end
      ST_F_RING:  if (rd_vld_q) avg_acc_q <= avg_acc_q + AVG_SUM_W'(ring_val);
      ST_F_AVG:   avg_prod_q <= AVG_PROD_W'(avg_acc_q) * AVG_PROD_W'(AVG_MULT);
      ST_S_TWAIT: if (div_stat.done) tm_q <= div_r;
      ST_S_PWAIT: if (div_stat.done) p_q <= div_r;
      ST_S_IWAIT: begin
        if (div_stat.done) begin
          // An index equal to the table length wraps to the first entry.
          idx_q <= (div_q >= DIV_Q_W'(COS_TABLE_ENTRIES)) ? '0 : div_q[CIDX_W-1:0];
        end
      end
      ST_S_COS:   cos_q <= cos_rom[idx_q];
      ST_S_MUL:   mprod_q <= $signed({1'b0, act_w}) * cos_q;
      ST_S_ACC:   sacc_q <= sacc_q + ACC_W'(mprod_q);
      ST_S_DONE:  if (!out_valid_q || out_ready_i) duty_q <= duty_sat;
      default: ;
    endcase
  end

  awtm_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i ({quo_q[WEIGHT_W-2:0], qbit}),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  awtm_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (NOTE_COUNT)
  ) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (note_q),
    .wdata_i (avg_prod_q[AVG_SHIFT +: WEIGHT_W]),
    .re_i    (act_re),
    .raddr_i (note_q),
    .rdata_o (act_rdata)
  );

  awtm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (div_x),
    .stat_o  (div_stat),
    .q_o     (div_q),
    .r_o     (div_r)
  );

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("modulo unit started while busy");

  a_result_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_S_DONE)
    else $error("result raised outside the end of a sample");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= ROW_W'(HISTORY_DEPTH - 1))
    else $error("ring slot out of range");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S_COS) |-> (int'(idx_q) < COS_TABLE_ENTRIES))
    else $error("cosine index out of range");
`endif

endmodule
`default_nettype wire
